### rtl/ppu_pkg.sv
// ----------------------------------------------------------------------------
// ppu_pkg: shared types and constants of the particle pool update block
// Beat layouts, the stored particle record, item kind codes and the
// constants of the divide-by-1000 step.
// ----------------------------------------------------------------------------
`default_nettype none

package ppu_pkg;

	// Default number of particle slots.
	localparam int POOL_DEPTH_DEF = 128;

	// Item kinds carried on the input tuser.
	localparam int KIND_W = 2;
	localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

	// Beat widths, padded to whole bytes.
	localparam int IN_DATA_W  = 136;
	localparam int OUT_DATA_W = 80;

	// Rounding bias and reciprocal for q = (n + 500) / 1000.
	// The sum is first shifted right by three, then divided by 125 through
	// a multiply by ceil(2^36 / 125), exact for quotients of 29-bit values.
	localparam logic [31:0] ROUND_BIAS = 32'd500;
	localparam logic [29:0] DIV_MUL    = 30'd549755814;
	localparam int          DIV_SHIFT  = 36;

	// Input beat, first field in the lowest bits.
	typedef struct packed {
		logic               pad;
		logic [6:0]         entry_index;
		logic [15:0]        delta_ms;
		logic [15:0]        life_ms;
		logic signed [15:0] acc_y;
		logic signed [15:0] acc_x;
		logic signed [15:0] vel_y;
		logic signed [15:0] vel_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_x;
	} in_data_t;

	// Output beat, first field in the lowest bits.
	typedef struct packed {
		logic [5:0]         pad;
		logic [15:0]        entry_total_life;
		logic [15:0]        entry_life;
		logic signed [15:0] entry_pos_y;
		logic signed [15:0] entry_pos_x;
		logic               entry_valid;
		logic               accepted;
		logic [7:0]         live_count;
	} out_data_t;

	// One particle slot as stored in the pool memory.
	typedef struct packed {
		logic [15:0]        total_life;
		logic [15:0]        life;
		logic signed [15:0] acc_y;
		logic signed [15:0] acc_x;
		logic signed [15:0] vel_y;
		logic signed [15:0] vel_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_x;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

### rtl/particle_pool_update.sv
// ----------------------------------------------------------------------------
// particle_pool_update: bounded particle pool with create, tick and read
// Keeps live particles packed at the front of one pool memory and updates
// them in place with semi-implicit Euler steps.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the s_axis channel; tuser holds the kind (create, tick,
// read) and tdata the particle fields, tick delta and read index. Every
// item returns exactly one beat on the m_axis channel with the live count,
// the create flag and, for a read, the slot contents.
// A create or a kind that does nothing goes from acceptance straight to the
// push state; a read passes a read-data state first for the memory read.
// A tick walks the live slots in order: each surviving slot passes a compare
// state, then the velocity and position increments through the four-stage
// advance units, one after the other since the position uses the new
// velocity, and each removed slot passes only the compare state.
// One item is worked on at a time; the next item is accepted as soon as the
// previous result sits in the output register, even if the receiver has
// not taken it. A stalled receiver holds the result beat steady and blocks
// only the completion of the following item.
// Reset empties the pool at once; no clearing pass of the memory is run.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_pool_update #(
	parameter int POOL_DEPTH = ppu_pkg::POOL_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// Fields from bit 0: pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, life_ms,
	// delta_ms, entry_index, zero pad.
	input  wire logic [ppu_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// Fields from bit 0: kind.
	input  wire logic [ppu_pkg::KIND_W-1:0]     s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// Fields from bit 0: live_count, accepted, entry_valid, entry_pos_x,
	// entry_pos_y, entry_life, entry_total_life, zero pad.
	output logic [ppu_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

	import ppu_pkg::*;

	localparam int AW = $clog2(POOL_DEPTH);
	localparam int CW = $clog2(POOL_DEPTH + 1);
	localparam int XW = (CW > 7) ? CW : 7;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RDAT = 6'b000010,
		ST_EVAL = 6'b000100,
		ST_VEL  = 6'b001000,
		ST_POS  = 6'b010000,
		ST_PUSH = 6'b100000
	} state_t;

	state_t             state_q;
	in_data_t           din;
	entry_t             rd_ent;
	entry_t             ent_q;
	entry_t             new_ent;
	entry_t             upd_ent;
	out_data_t          out_q;
	out_data_t          rd_q;
	out_data_t          push_beat;

	logic [CW-1:0]      live_q;
	logic [CW-1:0]      i_q;
	logic [CW-1:0]      live_dec;
	logic [CW-1:0]      next_i;
	logic [15:0]        delta_q;
	logic [6:0]         idx_q;
	logic signed [15:0] vel_x_q, vel_y_q;
	logic               out_valid_q;
	logic               res_acc_q;
	logic               room;
	logic               kill;
	logic               read_ok;
	logic               push_go;

	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

	logic               adv_go;
	logic signed [15:0] base_x, base_y, rate_x, rate_y;
	logic               done_x, done_y;
	logic               lanes_done;
	logic signed [15:0] res_x, res_y;

	assign din     = in_data_t'(s_axis_tdata);
	assign rd_ent  = entry_t'(ram_rdata);
	assign room    = live_q < CW'(POOL_DEPTH);
	assign kill    = delta_q > rd_ent.life;
	assign live_dec = live_q - CW'(1);
	assign next_i  = i_q + CW'(1);
	assign read_ok = XW'(idx_q) < XW'(live_q);

	// Both lanes start together and finish in the same cycle.
	assign lanes_done = done_x & done_y;

	// The result beat moves into the output register once that is free.
	assign push_go = (state_q == ST_PUSH) && (!out_valid_q || m_axis_tready);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// Record for a new particle.
	always_comb begin
		new_ent.pos_x      = din.pos_x;
		new_ent.pos_y      = din.pos_y;
		new_ent.vel_x      = din.vel_x;
		new_ent.vel_y      = din.vel_y;
		new_ent.acc_x      = din.acc_x;
		new_ent.acc_y      = din.acc_y;
		new_ent.life       = din.life_ms;
		new_ent.total_life = din.life_ms;
	end

	// Updated record of a surviving slot.
	always_comb begin
		upd_ent            = ent_q;
		upd_ent.pos_x      = res_x;
		upd_ent.pos_y      = res_y;
		upd_ent.vel_x      = vel_x_q;
		upd_ent.vel_y      = vel_y_q;
		upd_ent.life       = ent_q.life - delta_q;
	end

	// Complete result beat: staged slot fields plus count and create flag.
	always_comb begin
		push_beat            = rd_q;
		push_beat.live_count = 8'(live_q);
		push_beat.accepted   = res_acc_q;
	end

	// Advance unit operands: velocity step from the fresh read, then the
	// position step with the velocity just produced.
	always_comb begin
		if (state_q == ST_EVAL) begin
			base_x = rd_ent.vel_x;
			base_y = rd_ent.vel_y;
			rate_x = rd_ent.acc_x;
			rate_y = rd_ent.acc_y;
		end else begin
			base_x = ent_q.pos_x;
			base_y = ent_q.pos_y;
			rate_x = res_x;
			rate_y = res_y;
		end
	end

	// Memory accesses and advance starts.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(i_q);
		ram_wdata = upd_ent;
		ram_re    = 1'b0;
		ram_raddr = AW'(next_i);
		adv_go    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					unique case (s_axis_tuser)
						KIND_CREATE: begin
							ram_we    = room;
							ram_waddr = AW'(live_q);
							ram_wdata = new_ent;
						end
						KIND_READ: begin
							ram_re    = 1'b1;
							ram_raddr = AW'(din.entry_index);
						end
						KIND_TICK: begin
							ram_re    = (live_q != '0);
							ram_raddr = '0;
						end
						default: begin
							ram_re = 1'b0;
						end
					endcase
				end
			end
			ST_EVAL: begin
				if (kill) begin
					// The last live slot moves in and is processed here.
					ram_re    = (i_q < live_dec);
					ram_raddr = AW'(live_dec);
				end else begin
					adv_go = 1'b1;
				end
			end
			ST_VEL: begin
				adv_go = lanes_done;
			end
			ST_POS: begin
				if (lanes_done) begin
					ram_we = 1'b1;
					ram_re = (next_i < live_q);
				end
			end
			ST_RDAT, ST_PUSH: begin
				ram_re = 1'b0;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	// Sequencer, pool count and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			live_q      <= '0;
			i_q         <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			rd_q        <= '0;
			ent_q       <= '0;
			delta_q     <= '0;
			idx_q       <= '0;
			vel_x_q     <= '0;
			vel_y_q     <= '0;
			res_acc_q   <= 1'b0;
		end else begin
			if (push_go) begin
				out_q       <= push_beat;
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						delta_q   <= din.delta_ms;
						idx_q     <= din.entry_index;
						res_acc_q <= 1'b0;
						rd_q      <= '0;
						unique case (s_axis_tuser)
							KIND_CREATE: begin
								if (room) begin
									live_q    <= live_q + CW'(1);
									res_acc_q <= 1'b1;
								end
								state_q <= ST_PUSH;
							end
							KIND_READ: begin
								state_q <= ST_RDAT;
							end
							KIND_TICK: begin
								i_q     <= '0;
								state_q <= (live_q != '0) ? ST_EVAL : ST_PUSH;
							end
							default: begin
								state_q <= ST_PUSH;
							end
						endcase
					end
				end
				ST_RDAT: begin
					if (read_ok) begin
						rd_q.entry_valid      <= 1'b1;
						rd_q.entry_pos_x      <= rd_ent.pos_x;
						rd_q.entry_pos_y      <= rd_ent.pos_y;
						rd_q.entry_life       <= rd_ent.life;
						rd_q.entry_total_life <= rd_ent.total_life;
					end
					state_q <= ST_PUSH;
				end
				ST_EVAL: begin
					ent_q <= rd_ent;
					if (kill) begin
						live_q <= live_dec;
						if (!(i_q < live_dec)) begin
							state_q <= ST_PUSH;
						end
					end else begin
						state_q <= ST_VEL;
					end
				end
				ST_VEL: begin
					if (lanes_done) begin
						vel_x_q <= res_x;
						vel_y_q <= res_y;
						state_q <= ST_POS;
					end
				end
				ST_POS: begin
					if (lanes_done) begin
						i_q     <= next_i;
						state_q <= (next_i < live_q) ? ST_EVAL : ST_PUSH;
					end
				end
				ST_PUSH: begin
					// The output register is held until the receiver frees it.
					if (push_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	ppu_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (POOL_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ppu_adv u_adv_x (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (adv_go),
		.base   (base_x),
		.rate   (rate_x),
		.delta  (delta_q),
		.done   (done_x),
		.result (res_x)
	);

	ppu_adv u_adv_y (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (adv_go),
		.base   (base_y),
		.rate   (rate_y),
		.delta  (delta_q),
		.done   (done_y),
		.result (res_y)
	);

endmodule

`default_nettype wire

### rtl/ppu_ram.sv
// ----------------------------------------------------------------------------
// ppu_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds
// while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/ppu_adv.sv
// ----------------------------------------------------------------------------
// ppu_adv: one Euler increment with rounding and saturation
// Computes sat16(base + round(rate * delta / 1000)) in four pipeline
// stages: multiply, bias and pre-shift, reciprocal multiply, add and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_adv (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go,
	input  wire logic signed [15:0] base,
	input  wire logic signed [15:0] rate,
	input  wire logic        [15:0] delta,
	output logic                    done,
	output logic signed      [15:0] result
);

	import ppu_pkg::*;

	logic [15:0]        rate_mag;
	logic [31:0]        biased;
	logic [22:0]        quot;
	logic signed [23:0] sum;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic [31:0]        mag_s1;
	logic               neg_s1, neg_s2, neg_s3;
	logic signed [15:0] base_s1, base_s2, base_s3;
	logic [28:0]        n_s2;
	logic [58:0]        prod_s3;
	logic signed [15:0] res_s4;

	// Magnitude of the rate; the most negative value maps to 32768.
	assign rate_mag = rate[15] ? (~rate + 16'd1) : rate;

	// Rounding bias, then the divide by eight part of the divide by 1000.
	assign biased = mag_s1 + ROUND_BIAS;

	// Quotient and signed sum, wide enough that it cannot wrap.
	assign quot = prod_s3[58:DIV_SHIFT];
	assign sum  = neg_s3 ? (24'(base_s3) - $signed({1'b0, quot}))
	                     : (24'(base_s3) + $signed({1'b0, quot}));

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= go;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Datapath stages.
	always_ff @(posedge clk) begin
		mag_s1  <= rate_mag * delta;
		neg_s1  <= rate[15];
		base_s1 <= base;

		n_s2    <= biased[31:3];
		neg_s2  <= neg_s1;
		base_s2 <= base_s1;

		prod_s3 <= n_s2 * DIV_MUL;
		neg_s3  <= neg_s2;
		base_s3 <= base_s2;

		if (sum > 24'sd32767) begin
			res_s4 <= 16'sh7FFF;
		end else if (sum < -24'sd32768) begin
			res_s4 <= 16'sh8000;
		end else begin
			res_s4 <= sum[15:0];
		end
	end

	assign done   = v_s4;
	assign result = res_s4;

endmodule

`default_nettype wire

### rtl/ppu_check.sv
// ----------------------------------------------------------------------------
// ppu_check: port-level checks of the particle pool update block
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_check #(
	parameter int POOL_DEPTH = ppu_pkg::POOL_DEPTH_DEF
) (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           m_axis_tvalid,
	input wire logic                           m_axis_tready,
	input wire logic [ppu_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	import ppu_pkg::*;

	out_data_t res;
	assign res = out_data_t'(m_axis_tdata);

	// A stalled result beat stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
	else $error("result beat changed while stalled");

	// The live count never exceeds the pool size.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (POOL_DEPTH > 255) || (32'(res.live_count) <= POOL_DEPTH))
	else $error("live count above pool depth");

	// A stored create and a valid read never share a beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(res.accepted && res.entry_valid))
	else $error("create and read flags both set");

	// Slot fields are zero unless a valid read produced them.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !res.entry_valid |->
			res.entry_pos_x == '0 && res.entry_pos_y == '0 &&
			res.entry_life == '0 && res.entry_total_life == '0)
	else $error("slot fields set without a valid read");

	// A stored create leaves at least one live particle.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.accepted |-> (POOL_DEPTH > 255) || (res.live_count != '0))
	else $error("create stored with an empty pool");

endmodule

bind particle_pool_update ppu_check #(
	.POOL_DEPTH (POOL_DEPTH)
) u_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
